### rtl/hsvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV classifier package
// Shared types, register codes and hue constants of the HSV range classifier.
// ----------------------------------------------------------------------------
package hsvc_pkg;

	localparam int HUE_W   = 13;   // hue and hue bounds, sixteenths of a degree
	localparam int LIM_W   = 9;    // saturation and value thresholds
	localparam int CHAN_W  = 8;    // one colour channel
	localparam int QUO_W   = 10;   // quotient of 960*|num|/delta, at most 960
	localparam int NUMER_W = CHAN_W + QUO_W;   // 960*|num| fits in 18 bits
	localparam int DIV_CELLS = QUO_W;

	localparam logic [HUE_W-1:0] HUE_RED_WRAP = 13'd5760;
	localparam logic [HUE_W-1:0] HUE_GREEN    = 13'd1920;
	localparam logic [HUE_W-1:0] HUE_BLUE     = 13'd3840;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_HUE_LOW_A  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HUE_HIGH_A = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SAT_MIN_A  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_VAL_MIN_A  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HUE_LOW_B  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HUE_HIGH_B = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SAT_MIN_B  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_VAL_MIN_B  = 3'd7;

	typedef struct packed {
		logic [HUE_W-1:0] hue_low_a;
		logic [HUE_W-1:0] hue_high_a;
		logic [LIM_W-1:0] sat_min_a;
		logic [LIM_W-1:0] val_min_a;
		logic [HUE_W-1:0] hue_low_b;
		logic [HUE_W-1:0] hue_high_b;
		logic [LIM_W-1:0] sat_min_b;
		logic [LIM_W-1:0] val_min_b;
	} cfg_t;

	// Token handed from one divider cell to the next.
	typedef struct packed {
		logic              vld;
		logic [CHAN_W-1:0] rem;     // partial remainder, below dvs unless delta is zero
		logic [QUO_W-1:0]  numer;   // dividend bits still to be shifted in
		logic [QUO_W-1:0]  quo;     // quotient bits produced so far
		logic [CHAN_W-1:0] dvs;     // divisor: max minus min channel
		logic [HUE_W-1:0]  base;    // hue base of the sector
		logic              neg;     // channel difference was negative
		logic              grey;    // delta is zero, hue forced to zero
		logic              ok_a;    // saturation and value tests of range A
		logic              ok_b;    // saturation and value tests of range B
	} cell_t;

endpackage

### rtl/hsv_range_pixel_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV range pixel classifier
// Classifies RGB pixels against two configurable HSV windows, one per clock.
// ----------------------------------------------------------------------------
// A pixel transaction is taken on every rising edge at which start is high;
// busy is tied low, so a new pixel may be presented in every cycle and the
// block sustains one pixel per clock.
// Each pixel produces exactly one result transaction: done is high for one
// cycle with mask_bit alongside. Results leave in the order the pixels
// arrived.
// The pipeline is shaped by the hue division: a front end of two stages, a row
// of ten divider cells (one quotient bit each) and two back-end stages that
// form the hue and compare it with the windows.
// The receiver cannot stall the block; a result not taken in its cycle is
// simply gone, so the consumer must sample done on every edge.
// The eight range registers sit on the APB port at byte offsets 4*index.
// Reset clears the pipeline valid flags, so no stray done appears, and loads
// the registers with a single red wrap window in range A and range B off.
// Registers are meant to be rewritten only while no pixel is in flight.
// ----------------------------------------------------------------------------
module hsv_range_pixel_classifier_unit import hsvc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              done,
	output logic              mask_bit,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register file. Values are truncated to the width of each register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_low_a  <= 13'd5360;
			cfg_q.hue_high_a <= 13'd160;
			cfg_q.sat_min_a  <= 9'd90;
			cfg_q.val_min_a  <= 9'd60;
			cfg_q.hue_low_b  <= 13'd0;
			cfg_q.hue_high_b <= 13'd0;
			cfg_q.sat_min_b  <= 9'd0;
			cfg_q.val_min_b  <= 9'd256;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HUE_LOW_A:  cfg_q.hue_low_a  <= pwdata[HUE_W-1:0];
				REG_HUE_HIGH_A: cfg_q.hue_high_a <= pwdata[HUE_W-1:0];
				REG_SAT_MIN_A:  cfg_q.sat_min_a  <= pwdata[LIM_W-1:0];
				REG_VAL_MIN_A:  cfg_q.val_min_a  <= pwdata[LIM_W-1:0];
				REG_HUE_LOW_B:  cfg_q.hue_low_b  <= pwdata[HUE_W-1:0];
				REG_HUE_HIGH_B: cfg_q.hue_high_b <= pwdata[HUE_W-1:0];
				REG_SAT_MIN_B:  cfg_q.sat_min_b  <= pwdata[LIM_W-1:0];
				REG_VAL_MIN_B:  cfg_q.val_min_b  <= pwdata[LIM_W-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Read-back multiplexer; unused upper bits read as zero.
	always_comb begin
		unique case (reg_idx)
			REG_HUE_LOW_A:  prdata = {19'b0, cfg_q.hue_low_a};
			REG_HUE_HIGH_A: prdata = {19'b0, cfg_q.hue_high_a};
			REG_SAT_MIN_A:  prdata = {23'b0, cfg_q.sat_min_a};
			REG_VAL_MIN_A:  prdata = {23'b0, cfg_q.val_min_a};
			REG_HUE_LOW_B:  prdata = {19'b0, cfg_q.hue_low_b};
			REG_HUE_HIGH_B: prdata = {19'b0, cfg_q.hue_high_b};
			REG_SAT_MIN_B:  prdata = {23'b0, cfg_q.sat_min_b};
			REG_VAL_MIN_B:  prdata = {23'b0, cfg_q.val_min_b};
			default:        prdata = '0;
		endcase
	end

	// The chain: front end, then one cell per quotient bit, then back end.
	cell_t chain [DIV_CELLS+1];

	hsvc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.cfg    (cfg_q),
		.tok    (chain[0])
	);

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		hsvc_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	hsvc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok      (chain[DIV_CELLS]),
		.cfg      (cfg_q),
		.done     (done),
		.mask_bit (mask_bit)
	);

endmodule

### rtl/hsvc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV classifier front end
// Finds max, min and sector, forms the hue dividend and the S/V tests.
// ----------------------------------------------------------------------------
module hsvc_front import hsvc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	input  cfg_t              cfg,
	output cell_t             tok
);

	logic              vld_s1;
	logic [CHAN_W-1:0] maxv_s1;
	logic [CHAN_W-1:0] delta_s1;
	logic [CHAN_W-1:0] num_abs_s1;
	logic              neg_s1;
	logic [HUE_W-1:0]  base_s1;

	logic              red_max, green_max;
	logic [CHAN_W-1:0] maxv, minv;
	logic [CHAN_W:0]   num;
	logic [CHAN_W:0]   num_mag;
	logic [HUE_W-1:0]  base;

	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		maxv = red_max ? red : (green_max ? green : blue);
		minv = red;
		if (green < minv) begin
			minv = green;
		end
		if (blue < minv) begin
			minv = blue;
		end
		if (red_max) begin
			num = {1'b0, green} - {1'b0, blue};
		end else if (green_max) begin
			num = {1'b0, blue} - {1'b0, red};
		end else begin
			num = {1'b0, red} - {1'b0, green};
		end
		num_mag = num[CHAN_W] ? (~num + 1'b1) : num;
		if (red_max) begin
			base = num[CHAN_W] ? HUE_RED_WRAP : '0;
		end else if (green_max) begin
			base = HUE_GREEN;
		end else begin
			base = HUE_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		maxv_s1    <= maxv;
		delta_s1   <= maxv - minv;
		num_abs_s1 <= num_mag[CHAN_W-1:0];
		neg_s1     <= num[CHAN_W];
		base_s1    <= base;
	end

	// Second stage: dividend 960*|num| = 1024*|num| - 64*|num|, and the
	// saturation test delta*256 >= sat_min*max without a division.
	logic [NUMER_W-1:0]        numer;
	logic [LIM_W+CHAN_W-1:0]   sat_lhs;
	logic [LIM_W+CHAN_W-1:0]   sat_rhs_a, sat_rhs_b;
	logic                      ok_a, ok_b;

	always_comb begin
		numer = ({num_abs_s1, {QUO_W{1'b0}}}) - ({4'b0, num_abs_s1, 6'b0});
		sat_lhs   = {1'b0, delta_s1, 8'b0};
		sat_rhs_a = cfg.sat_min_a * maxv_s1;
		sat_rhs_b = cfg.sat_min_b * maxv_s1;
		ok_a = (sat_lhs >= sat_rhs_a) && ({1'b0, maxv_s1} >= cfg.val_min_a);
		ok_b = (sat_lhs >= sat_rhs_b) && ({1'b0, maxv_s1} >= cfg.val_min_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok <= '0;
		end else begin
			tok.vld   <= vld_s1;
			tok.rem   <= numer[NUMER_W-1:QUO_W];
			tok.numer <= numer[QUO_W-1:0];
			tok.quo   <= '0;
			tok.dvs   <= delta_s1;
			tok.base  <= base_s1;
			tok.neg   <= neg_s1;
			tok.grey  <= (delta_s1 == '0);
			tok.ok_a  <= ok_a;
			tok.ok_b  <= ok_b;
		end
	end

endmodule

### rtl/hsvc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV classifier divider cell
// One restoring division step: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module hsvc_div_cell import hsvc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t tok_in,
	output cell_t tok_out
);

	logic [CHAN_W:0]   trial;
	logic              ge;
	logic [CHAN_W:0]   diff;
	logic [CHAN_W-1:0] rem_next;

	always_comb begin
		trial    = {tok_in.rem, tok_in.numer[QUO_W-1]};
		diff     = trial - {1'b0, tok_in.dvs};
		ge       = (trial >= {1'b0, tok_in.dvs});
		rem_next = ge ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out.vld   <= tok_in.vld;
			tok_out.rem   <= rem_next;
			tok_out.numer <= {tok_in.numer[QUO_W-2:0], 1'b0};
			tok_out.quo   <= {tok_in.quo[QUO_W-2:0], ge};
			tok_out.dvs   <= tok_in.dvs;
			tok_out.base  <= tok_in.base;
			tok_out.neg   <= tok_in.neg;
			tok_out.grey  <= tok_in.grey;
			tok_out.ok_a  <= tok_in.ok_a;
			tok_out.ok_b  <= tok_in.ok_b;
		end
	end

endmodule

### rtl/hsvc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV classifier back end
// Turns quotient and remainder into the hue and tests both hue windows.
// ----------------------------------------------------------------------------
module hsvc_back import hsvc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t tok,
	input  cfg_t  cfg,
	output logic  done,
	output logic  mask_bit
);

	logic             vld_s1;
	logic [HUE_W-1:0] hue_s1;
	logic             ok_a_s1, ok_b_s1;
	logic             done_q, mask_bit_q;

	logic [HUE_W-1:0] quo_ext;
	logic [HUE_W-1:0] hue;

	// A negative difference needs the ceiling of the quotient, subtracted.
	always_comb begin
		quo_ext = {{(HUE_W-QUO_W){1'b0}}, tok.quo};
		if (tok.grey) begin
			hue = '0;
		end else if (tok.neg) begin
			hue = tok.base - quo_ext - {{(HUE_W-1){1'b0}}, (tok.rem != '0)};
		end else begin
			hue = tok.base + quo_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tok.vld;
		end
	end

	always_ff @(posedge clk) begin
		hue_s1  <= hue;
		ok_a_s1 <= tok.ok_a;
		ok_b_s1 <= tok.ok_b;
	end

	function automatic logic hue_in(input logic [HUE_W-1:0] h,
	                                input logic [HUE_W-1:0] lo,
	                                input logic [HUE_W-1:0] hi);
		logic above, below;
		above = (h >= lo);
		below = (h <= hi);
		return (lo <= hi) ? (above && below) : (above || below);
	endfunction

	logic hit;

	always_comb begin
		hit = (ok_a_s1 && hue_in(hue_s1, cfg.hue_low_a, cfg.hue_high_a))
		   || (ok_b_s1 && hue_in(hue_s1, cfg.hue_low_b, cfg.hue_high_b));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mask_bit_q <= hit;
	end

	assign done     = done_q;
	assign mask_bit = mask_bit_q;

endmodule

### tb/sv/hsv_range_pixel_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV range pixel classifier testbench
// Drives RGB pixels through the classifier under a series of window settings
// and checks every mask bit against an in-bench HSV model or a typed table value.
// ----------------------------------------------------------------------------
module hsv_range_pixel_classifier_unit_tb import hsvc_pkg::*;;

	// Cycles from pixel acceptance to its result.
	localparam int PIPE_LATENCY   = 13;
	// Cycles without any accepted transaction before the run is abandoned.
	localparam int STALL_LIMIT    = 2000;
	localparam int N_DIRECTED     = 20;
	localparam int N_PHASES       = 10;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int MAX_REPORTS    = 10;

	// One row of the directed table. Where "typed" is set, the mask is the
	// expected result as read straight off the behaviour; otherwise the
	// model below supplies it.
	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              typed;
		logic              mask;
	} pixel_row_t;

	// One outstanding mask, with its pixel kept for the mismatch report.
	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              mask;
	} pending_mask_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              done;
	logic              mask_bit;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [4:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// Shadow copy of the window registers, updated as each write completes.
	cfg_t          window_cfg;
	pending_mask_t pending_masks[$];
	pixel_row_t    directed_rows[N_DIRECTED];
	int            mismatch_count;
	int            stall_cycles;

	hsv_range_pixel_classifier_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.done     (done),
		.mask_bit (mask_bit),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Model of the classifier.
	// ------------------------------------------------------------------------

	// A window matches when the hue lies inside it (wrapping past 360 degrees
	// when the lower bound exceeds the upper one), the saturation test
	// delta*256 >= sat_min*max holds, and the value reaches val_min.
	function automatic bit window_hit(input int unsigned hue, input int unsigned delta,
			input int unsigned maxv, input int unsigned lo, input int unsigned hi,
			input int unsigned smin, input int unsigned vmin);
		bit hue_ok;
		if (lo <= hi) begin
			hue_ok = (hue >= lo) && (hue <= hi);
		end else begin
			hue_ok = (hue >= lo) || (hue <= hi);
		end
		return hue_ok && (delta * 256 >= smin * maxv) && (maxv >= vmin);
	endfunction

	// Hue in sixteenths of a degree is formed by exact integer division of a
	// numerator that is never negative. Ties in the maximum go to red, then
	// to green; a grey pixel has a hue of zero.
	function automatic logic predict_mask(input logic [CHAN_W-1:0] r_in,
			input logic [CHAN_W-1:0] g_in, input logic [CHAN_W-1:0] b_in);
		int          rr;
		int          gg;
		int          bb;
		int          maxv;
		int          minv;
		int          delta;
		int          num;
		int          base;
		int unsigned hue;
		rr = int'(r_in);
		gg = int'(g_in);
		bb = int'(b_in);
		maxv = rr;
		minv = rr;
		if (gg > maxv) maxv = gg;
		if (bb > maxv) maxv = bb;
		if (gg < minv) minv = gg;
		if (bb < minv) minv = bb;
		delta = maxv - minv;
		hue = 0;
		if (delta != 0) begin
			if (maxv == rr) begin
				num = gg - bb;
				base = (num < 0) ? int'(HUE_RED_WRAP) : 0;
			end else if (maxv == gg) begin
				num = bb - rr;
				base = int'(HUE_GREEN);
			end else begin
				num = rr - gg;
				base = int'(HUE_BLUE);
			end
			hue = (base * delta + 960 * num) / delta;
		end
		return window_hit(hue, delta, maxv,
				32'(window_cfg.hue_low_a), 32'(window_cfg.hue_high_a),
				32'(window_cfg.sat_min_a), 32'(window_cfg.val_min_a))
			|| window_hit(hue, delta, maxv,
				32'(window_cfg.hue_low_b), 32'(window_cfg.hue_high_b),
				32'(window_cfg.sat_min_b), 32'(window_cfg.val_min_b));
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------

	// Presents one pixel and holds it until the block accepts it. On return
	// the caller stands just after the accepting edge with start still high,
	// so a following pixel can go out in the very next cycle.
	task automatic drive_pixel(input logic [CHAN_W-1:0] r_in, input logic [CHAN_W-1:0] g_in,
			input logic [CHAN_W-1:0] b_in, input logic typed, input logic typed_mask);
		pending_mask_t entry;
		red   <= r_in;
		green <= g_in;
		blue  <= b_in;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		entry.r = r_in;
		entry.g = g_in;
		entry.b = b_in;
		entry.mask = typed ? typed_mask : predict_mask(r_in, g_in, b_in);
		pending_masks = {pending_masks, entry};
	endtask

	task automatic idle_gap(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// The sender holds off until every outstanding mask has come back. Each
	// pixel yields exactly one result, so an empty queue means the pipeline
	// is empty as well.
	task automatic drain_results;
		start <= 1'b0;
		while (pending_masks.size() != 0) @(posedge clk);
	endtask

	// One APB write: setup then access, finishing on the edge with pready.
	// psel is left high so that writes can run back to back; the caller
	// closes the bus once the last one is done.
	task automatic apb_write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_HUE_LOW_A:  window_cfg.hue_low_a  = value[HUE_W-1:0];
			REG_HUE_HIGH_A: window_cfg.hue_high_a = value[HUE_W-1:0];
			REG_SAT_MIN_A:  window_cfg.sat_min_a  = value[LIM_W-1:0];
			REG_VAL_MIN_A:  window_cfg.val_min_a  = value[LIM_W-1:0];
			REG_HUE_LOW_B:  window_cfg.hue_low_b  = value[HUE_W-1:0];
			REG_HUE_HIGH_B: window_cfg.hue_high_b = value[HUE_W-1:0];
			REG_SAT_MIN_B:  window_cfg.sat_min_b  = value[LIM_W-1:0];
			default:        window_cfg.val_min_b  = value[LIM_W-1:0];
		endcase
	endtask

	// Writes all eight window registers, in register order.
	task automatic program_windows(input cfg_t c);
		apb_write_reg(REG_HUE_LOW_A,  32'(c.hue_low_a));
		apb_write_reg(REG_HUE_HIGH_A, 32'(c.hue_high_a));
		apb_write_reg(REG_SAT_MIN_A,  32'(c.sat_min_a));
		apb_write_reg(REG_VAL_MIN_A,  32'(c.val_min_a));
		apb_write_reg(REG_HUE_LOW_B,  32'(c.hue_low_b));
		apb_write_reg(REG_HUE_HIGH_B, 32'(c.hue_high_b));
		apb_write_reg(REG_SAT_MIN_B,  32'(c.sat_min_b));
		apb_write_reg(REG_VAL_MIN_B,  32'(c.val_min_b));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result checking. Outputs are sampled on the rising edge, before the
	// design's own updates of that edge take effect, so the values seen are
	// those of the cycle the edge ends. The receiver cannot stall, so every
	// cycle with done high is one result transaction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		pending_mask_t head;
		if (arst_n && done) begin
			if (pending_masks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result transaction: mask_bit=%0b", mask_bit);
			end else begin
				head = pending_masks.pop_front();
				if (mask_bit !== head.mask) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mask_bit mismatch for rgb (%0d,%0d,%0d): expected %0b, got %0b",
							head.r, head.g, head.b, head.mask, mask_bit);
				end
			end
		end
	end

	// Watchdog: any accepted transaction on either port, or on the register
	// bus, counts as progress. A long run of cycles with none ends the test.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		int                phase;
		int                item;
		int                pick;
		bit                idle_ok;
		logic [CHAN_W-1:0] pr;
		logic [CHAN_W-1:0] pg;
		logic [CHAN_W-1:0] pb;
		cfg_t              next_cfg;

		arst_n  <= 1'b0;
		start   <= 1'b0;
		red     <= '0;
		green   <= '0;
		blue    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		mismatch_count = 0;
		stall_cycles   = 0;

		// After reset range A is a red wrap window and range B is switched
		// off by its value threshold of 256.
		window_cfg.hue_low_a  = 13'd5360;
		window_cfg.hue_high_a = 13'd160;
		window_cfg.sat_min_a  = 9'd90;
		window_cfg.val_min_a  = 9'd60;
		window_cfg.hue_low_b  = 13'd0;
		window_cfg.hue_high_b = 13'd0;
		window_cfg.sat_min_b  = 9'd0;
		window_cfg.val_min_b  = 9'd256;

		// Directed pixels under the reset windows. The typed rows cover black,
		// white, the primaries and the value threshold; the others probe the
		// two-way ties in the maximum, the saturation boundary and both hue
		// edges of the red wrap window.
		directed_rows = '{
			'{8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
			'{8'd255, 8'd0,   8'd0,   1'b1, 1'b1},
			'{8'd255, 8'd255, 8'd255, 1'b1, 1'b0},
			'{8'd0,   8'd255, 8'd0,   1'b1, 1'b0},
			'{8'd0,   8'd0,   8'd255, 1'b1, 1'b0},
			'{8'd60,  8'd0,   8'd0,   1'b1, 1'b1},
			'{8'd59,  8'd0,   8'd0,   1'b1, 1'b0},
			'{8'd1,   8'd0,   8'd0,   1'b1, 1'b0},
			'{8'd128, 8'd128, 8'd128, 1'b1, 1'b0},
			'{8'd255, 8'd255, 8'd0,   1'b0, 1'b0},
			'{8'd0,   8'd255, 8'd255, 1'b0, 1'b0},
			'{8'd255, 8'd0,   8'd255, 1'b0, 1'b0},
			'{8'd255, 8'd0,   8'd1,   1'b0, 1'b0},
			'{8'd255, 8'd10,  8'd0,   1'b0, 1'b0},
			'{8'd255, 8'd165, 8'd165, 1'b0, 1'b0},
			'{8'd255, 8'd166, 8'd166, 1'b0, 1'b0},
			'{8'd255, 8'd42,  8'd0,   1'b0, 1'b0},
			'{8'd255, 8'd43,  8'd0,   1'b0, 1'b0},
			'{8'd255, 8'd0,   8'd106, 1'b0, 1'b0},
			'{8'd255, 8'd0,   8'd107, 1'b0, 1'b0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (item = 0; item < N_DIRECTED; item++)
			drive_pixel(directed_rows[item].r, directed_rows[item].g, directed_rows[item].b,
				directed_rows[item].typed, directed_rows[item].mask);

		for (phase = 0; phase < N_PHASES; phase++) begin
			// Phase 0 runs on the reset windows. Later phases reprogram every
			// register, only once the pipeline has fully drained.
			if (phase != 0) begin
				drain_results();
				case (phase)
					1: begin
						// Everything at zero: both windows accept hue zero only.
						next_cfg = '0;
					end
					2: begin
						// Full-width values: range A can never match, while
						// range B spans every hue with no thresholds at all.
						next_cfg.hue_low_a  = '1;
						next_cfg.hue_high_a = '1;
						next_cfg.sat_min_a  = '1;
						next_cfg.val_min_a  = '1;
						next_cfg.hue_low_b  = '0;
						next_cfg.hue_high_b = '1;
						next_cfg.sat_min_b  = '0;
						next_cfg.val_min_b  = '0;
					end
					3: begin
						// A narrow green window demanding full saturation, and a
						// full-circle range B that is disabled by its value bound.
						next_cfg.hue_low_a  = 13'd1500;
						next_cfg.hue_high_a = 13'd2300;
						next_cfg.sat_min_a  = 9'd256;
						next_cfg.val_min_a  = 9'd0;
						next_cfg.hue_low_b  = 13'd0;
						next_cfg.hue_high_b = 13'd5760;
						next_cfg.sat_min_b  = 9'd0;
						next_cfg.val_min_b  = 9'd256;
					end
					default: begin
						// Random windows, mostly inside the documented ranges
						// with an occasional out-of-range bound or threshold.
						next_cfg.hue_low_a  = 13'(($urandom_range(0, 9) == 0) ?
							$urandom_range(0, 8191) : $urandom_range(0, 5760));
						next_cfg.hue_high_a = 13'(($urandom_range(0, 9) == 0) ?
							$urandom_range(0, 8191) : $urandom_range(0, 5760));
						next_cfg.hue_low_b  = 13'(($urandom_range(0, 9) == 0) ?
							$urandom_range(0, 8191) : $urandom_range(0, 5760));
						next_cfg.hue_high_b = 13'(($urandom_range(0, 9) == 0) ?
							$urandom_range(0, 8191) : $urandom_range(0, 5760));
						next_cfg.sat_min_a  = 9'(($urandom_range(0, 7) == 0) ?
							$urandom_range(0, 511) : $urandom_range(0, 256));
						next_cfg.sat_min_b  = 9'(($urandom_range(0, 7) == 0) ?
							$urandom_range(0, 511) : $urandom_range(0, 256));
						next_cfg.val_min_a  = 9'(($urandom_range(0, 9) == 0) ?
							$urandom_range(256, 511) : $urandom_range(0, 200));
						next_cfg.val_min_b  = 9'(($urandom_range(0, 9) == 0) ?
							$urandom_range(256, 511) : $urandom_range(0, 200));
					end
				endcase
				program_windows(next_cfg);
			end

			// Phase 6 is one long stretch at one pixel per clock.
			idle_ok = (phase != 6);

			for (item = 0; item < ITEMS_PER_PHASE; item++) begin
				pick = $urandom_range(0, 9);
				pr = 8'($urandom_range(0, 255));
				pg = 8'($urandom_range(0, 255));
				pb = 8'($urandom_range(0, 255));
				case (pick)
					0: begin
						// Grey pixel: no hue, saturation zero.
						pg = pr;
						pb = pr;
					end
					1: begin
						// Two channels made equal, at times sharing the maximum.
						case ($urandom_range(0, 2))
							0: pg = pr;
							1: pb = pg;
							default: pb = pr;
						endcase
					end
					2: begin
						// One channel at zero: full saturation.
						case ($urandom_range(0, 2))
							0: pr = '0;
							1: pg = '0;
							default: pb = '0;
						endcase
					end
					3: begin
						// Channels at the ends of their range.
						pr = $urandom_range(0, 1) ? 8'd255 : 8'd0;
						pg = $urandom_range(0, 1) ? 8'd255 : 8'd0;
						pb = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					end
					default: begin
					end
				endcase
				drive_pixel(pr, pg, pb, 1'b0, 1'b0);
				if (idle_ok && ($urandom_range(0, 99) < 3))
					idle_gap($urandom_range(1, 4));
			end
		end

		// Wait for the last masks, then keep watching the outputs
		// to catch any stray result transaction.
		drain_results();
		repeat (PIPE_LATENCY + 4) @(posedge clk);

		if (pending_masks.size() != 0)
			mismatch_count++;

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
